// ----- src/scan_point_curvature_top_macros.svh -----
// Assertion macros for the scan point curvature block.
// Needs only the clock and reset names passed in by the user of each macro.
`ifndef SCAN_POINT_CURVATURE_TOP_MACROS_SVH
`define SCAN_POINT_CURVATURE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPC_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/spc_pkg.sv -----
// Shared types and constants of the scan point curvature block.
// No dependencies; used by the result stream interface, the top level and the testbench.
package spc_pkg;

	localparam int OUT_COORD_W = 19;
	localparam int CURV_W      = 24;
	localparam int SQ_W        = 2 * CURV_W;
	localparam int TOTAL_W     = SQ_W + 2;
	localparam int REM_W       = CURV_W + 3;
	localparam int ROOT_IT_W   = $clog2(CURV_W);
	localparam int AXES        = 3;

	localparam logic [1:0]        AXIS_LAST = 2'd2;
	localparam logic [CURV_W-1:0] CURV_MAX  = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_RDWAIT,
		S_SQUARE,
		S_SQWAIT,
		S_ROOT,
		S_SEND
	} spc_state_t;

endpackage

// ----- src/spc_stream_if.sv -----
// Valid/ready channel interfaces for the scan point curvature block.
// Depends on spc_pkg for the result field widths.
interface spc_point_if #(
	parameter int COORD_WIDTH = 19
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_coord;
	logic signed [COORD_WIDTH-1:0] y_coord;
	logic signed [COORD_WIDTH-1:0] z_coord;
	logic                          end_of_scan;

	modport source (output valid, x_coord, y_coord, z_coord, end_of_scan, input ready);
	modport sink (input valid, x_coord, y_coord, z_coord, end_of_scan, output ready);
endinterface

interface spc_result_if ();
	import spc_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [OUT_COORD_W-1:0] out_x;
	logic signed [OUT_COORD_W-1:0] out_y;
	logic signed [OUT_COORD_W-1:0] out_z;
	logic [CURV_W-1:0]             curvature;
	logic                          curvature_valid;
	logic                          last_of_scan;

	modport source (output valid, out_x, out_y, out_z, curvature, curvature_valid,
		last_of_scan, input ready);
	modport sink (input valid, out_x, out_y, out_z, curvature, curvature_valid,
		last_of_scan, output ready);
endinterface

// ----- src/scan_point_curvature_top.sv -----
// A result with valid curvature takes window reads over the single memory port, three
// squarings and a square root of at most 24 steps; a result without curvature takes one
// read of its point. A new point is taken once all results of the previous one are queued,
// so the block does not take a new point while it still works on the last one.
// Reset clears the sequencer, the point count, the ring pointer and the output valid flag;
// the history memory is not cleared and no clearing pass runs.
module scan_point_curvature_top #(
	parameter int MIN_SCAN_POINTS = 20,
	parameter int HALF_WINDOW     = 5,
	parameter int COORD_WIDTH     = 19
) (
	input  logic          clk,
	input  logic          arst_n,
	spc_point_if.sink     points,
	spc_result_if.source  results
);
	import spc_pkg::*;
	`include "scan_point_curvature_top_macros.svh"

	localparam int DEPTH  = (MIN_SCAN_POINTS > 2 * HALF_WINDOW + 1) ?
		MIN_SCAN_POINTS : 2 * HALF_WINDOW + 1;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int AGE_W  = SLOT_W + 2;
	localparam int WIN_W  = $clog2(2 * HALF_WINDOW + 2);
	localparam int ACC_W  = COORD_WIDTH + $clog2(2 * HALF_WINDOW) + 2;
	localparam int MAGX_W = (ACC_W > CURV_W) ? ACC_W : CURV_W + 1;
	localparam int MEM_W  = AXES * COORD_WIDTH;

	localparam logic signed [ACC_W-1:0] TWO_H = ACC_W'(2 * HALF_WINDOW);

	// Control state.
	spc_state_t        state_q, state_n;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] wp_q;
	logic              out_vld_q;
	logic              rd_vld_s1;

	// Per-point plan and per-result sequencing.
	logic [SLOT_W-1:0] newest_q;
	logic [CNT_W-1:0]  cntv_q;
	logic              min_q;
	logic              scan_end_q;
	logic [AGE_W-1:0]  age_q;
	logic [AGE_W-1:0]  lo_q;
	logic [WIN_W-1:0]  j_q;
	logic              rd_ctr_s1;

	// History memory.
	logic [MEM_W-1:0]  hist_mem [DEPTH];
	logic [MEM_W-1:0]  rd_data_q;

	// Arithmetic.
	logic signed [ACC_W-1:0]       acc_q [AXES];
	logic signed [COORD_WIDTH-1:0] ctr_q [AXES];
	logic [1:0]                    ax_q;
	logic                          sat_q;
	logic [SQ_W-1:0]               sq_s1;
	logic                          sq_vld_s1;
	logic [TOTAL_W-1:0]            total_q;
	logic [REM_W-1:0]              rem_q;
	logic [CURV_W-1:0]             root_q;
	logic [ROOT_IT_W-1:0]          it_q;

	// Output register.
	logic signed [OUT_COORD_W-1:0] out_x_q, out_y_q, out_z_q;
	logic [CURV_W-1:0]             curv_q;
	logic                          curv_vld_q;
	logic                          last_q;

	// Combinational signals.
	logic                          accept_in;
	logic [CNT_W-1:0]              cntn;
	logic                          reach_min;
	logic                          plan_go;
	logic [AGE_W-1:0]              plan_hi;
	logic [AGE_W-1:0]              plan_lo;
	logic                          cv_c;
	logic [AGE_W-1:0]              rel_age;
	logic [AGE_W-1:0]              newest_ext;
	logic [AGE_W-1:0]              slot_full;
	logic [SLOT_W-1:0]             rd_slot;
	logic                          read_last;
	logic                          rd_en;
	logic                          load_out;
	logic                          start_emit;
	logic                          sat_c;
	logic signed [COORD_WIDTH-1:0] rd_coord [AXES];
	logic signed [ACC_W-1:0]       coord_ext [AXES];
	logic signed [ACC_W-1:0]       ctr_term [AXES];
	logic signed [ACC_W-1:0]       acc_sel;
	logic [ACC_W-1:0]              abs_u;
	logic [MAGX_W-1:0]             mag_x;
	logic                          mag_big;
	logic [CURV_W-1:0]             mag_lo;
	logic [REM_W-1:0]              rem_sh;
	logic [REM_W-1:0]              trial;

	assign accept_in = points.valid && points.ready;
	assign points.ready = (state_q == S_IDLE);

	// What an accepted point releases if plan_go: a run of results from age plan_hi to plan_lo.
	always_comb begin
		cntn      = (cnt_q < CNT_W'(DEPTH)) ? cnt_q + 1'b1 : CNT_W'(DEPTH);
		reach_min = (cntn >= CNT_W'(MIN_SCAN_POINTS));
		plan_go   = reach_min || points.end_of_scan;
		plan_hi   = (!reach_min || cnt_q < CNT_W'(MIN_SCAN_POINTS)) ?
			AGE_W'(cntn - 1'b1) : AGE_W'(HALF_WINDOW);
		plan_lo   = points.end_of_scan ? '0 : AGE_W'(HALF_WINDOW);
	end

	// A point has a curvature only if it has a full window inside a long enough scan.
	assign cv_c = min_q && (age_q >= AGE_W'(HALF_WINDOW)) &&
		(age_q + AGE_W'(HALF_WINDOW + 1) <= AGE_W'(cntv_q));

	assign sat_c = sat_q || (|total_q[TOTAL_W-1:SQ_W]);

	// Age to ring slot; the newest point of the scan sits at age zero.
	always_comb begin
		rel_age    = cv_c ? age_q + AGE_W'(HALF_WINDOW) - AGE_W'(j_q) : age_q;
		newest_ext = AGE_W'(newest_q);
		slot_full  = (newest_ext >= rel_age) ? newest_ext - rel_age :
			newest_ext + AGE_W'(DEPTH) - rel_age;
		rd_slot    = slot_full[SLOT_W-1:0];
		read_last  = !cv_c || (j_q == WIN_W'(2 * HALF_WINDOW));
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			rd_coord[a]  = rd_data_q[a*COORD_WIDTH +: COORD_WIDTH];
			coord_ext[a] = ACC_W'(rd_coord[a]);
			ctr_term[a]  = coord_ext[a] * TWO_H;
		end
	end

	// Magnitude of one axis difference; anything at or above 2^24 saturates the root.
	always_comb begin
		acc_sel = acc_q[ax_q];
		abs_u   = acc_sel[ACC_W-1] ? $unsigned(-acc_sel) : $unsigned(acc_sel);
		mag_x   = MAGX_W'(abs_u);
		mag_big = |mag_x[MAGX_W-1:CURV_W];
		mag_lo  = mag_x[CURV_W-1:0];
	end

	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], total_q[{it_q, 1'b0} +: 2]};
		trial  = REM_W'({root_q, 2'b01});
	end

	// Sequencer: next state and strobes.
	always_comb begin
		state_n    = state_q;
		rd_en      = 1'b0;
		load_out   = 1'b0;
		start_emit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept_in && plan_go) begin
					state_n    = S_READ;
					start_emit = 1'b1;
				end
			end
			S_READ: begin
				rd_en = 1'b1;
				if (read_last) begin
					state_n = S_RDWAIT;
				end
			end
			S_RDWAIT: begin
				state_n = cv_c ? S_SQUARE : S_SEND;
			end
			S_SQUARE: begin
				if (ax_q == AXIS_LAST) begin
					state_n = S_SQWAIT;
				end
			end
			S_SQWAIT: begin
				state_n = S_ROOT;
			end
			S_ROOT: begin
				if (sat_c || it_q == '0) begin
					state_n = S_SEND;
				end
			end
			S_SEND: begin
				if (!out_vld_q || results.ready) begin
					load_out = 1'b1;
					if (age_q == lo_q) begin
						state_n = S_IDLE;
					end else begin
						state_n    = S_READ;
						start_emit = 1'b1;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			wp_q      <= '0;
			out_vld_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			sq_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_n;
			rd_vld_s1 <= rd_en;
			sq_vld_s1 <= (state_q == S_SQUARE);
			if (accept_in) begin
				if (points.end_of_scan) begin
					cnt_q <= '0;
					wp_q  <= '0;
				end else begin
					cnt_q <= cntn;
					wp_q  <= (wp_q == SLOT_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
				end
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// History memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			hist_mem[wp_q] <= {points.z_coord, points.y_coord, points.x_coord};
		end
		if (rd_en) begin
			rd_data_q <= hist_mem[rd_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			newest_q   <= wp_q;
			cntv_q     <= cntn;
			min_q      <= reach_min;
			scan_end_q <= points.end_of_scan;
			age_q      <= plan_hi;
			lo_q       <= plan_lo;
		end
		if (load_out && age_q != lo_q) begin
			age_q <= age_q - 1'b1;
		end
		if (start_emit) begin
			j_q     <= '0;
			ax_q    <= '0;
			sat_q   <= 1'b0;
			total_q <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			it_q    <= ROOT_IT_W'(CURV_W - 1);
			for (int a = 0; a < AXES; a++) begin
				acc_q[a] <= '0;
			end
		end
		if (rd_en) begin
			j_q       <= j_q + 1'b1;
			rd_ctr_s1 <= !cv_c || (j_q == WIN_W'(HALF_WINDOW));
		end
		// The center point enters with weight -2*HALF_WINDOW and is kept for the echo.
		if (rd_vld_s1) begin
			for (int a = 0; a < AXES; a++) begin
				acc_q[a] <= rd_ctr_s1 ? acc_q[a] - ctr_term[a] : acc_q[a] + coord_ext[a];
				if (rd_ctr_s1) begin
					ctr_q[a] <= rd_coord[a];
				end
			end
		end
		if (state_q == S_SQUARE) begin
			sq_s1 <= mag_lo * mag_lo;
			ax_q  <= ax_q + 1'b1;
			if (mag_big) begin
				sat_q <= 1'b1;
			end
		end
		if (sq_vld_s1) begin
			total_q <= total_q + TOTAL_W'(sq_s1);
		end
		// Restoring square root, one result bit per cycle from the top pair of bits down.
		if (state_q == S_ROOT && !sat_c) begin
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[CURV_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[CURV_W-2:0], 1'b0};
			end
			it_q <= it_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x_q    <= OUT_COORD_W'(ctr_q[0]);
			out_y_q    <= OUT_COORD_W'(ctr_q[1]);
			out_z_q    <= OUT_COORD_W'(ctr_q[2]);
			curv_q     <= !cv_c ? '0 : (sat_c ? CURV_MAX : root_q);
			curv_vld_q <= cv_c;
			last_q     <= scan_end_q && (age_q == '0);
		end
	end

	assign results.valid           = out_vld_q;
	assign results.out_x           = out_x_q;
	assign results.out_y           = out_y_q;
	assign results.out_z           = out_z_q;
	assign results.curvature       = curv_q;
	assign results.curvature_valid = curv_vld_q;
	assign results.last_of_scan    = last_q;

	`SPC_ASSERT_NEXT(a_scan_restart, clk, arst_n, accept_in && points.end_of_scan, cnt_q == '0 && wp_q == '0, "scan end did not restart the counters")
	`SPC_ASSERT_IMPL(a_read_in_ring, clk, arst_n, state_q == S_READ, rel_age < AGE_W'(DEPTH), "window read outside the history ring")
	`SPC_ASSERT_IMPL(a_invalid_zero, clk, arst_n, results.valid && !results.curvature_valid, results.curvature == '0, "invalid curvature is not zero")

endmodule

// ----- sim/scan_point_curvature_top_tb.sv -----
// Self-checking testbench for scan_point_curvature_top: directed and random scan lines.
// Depends on spc_pkg, spc_point_if and spc_result_if; predicts every reported point in place.
`timescale 1ns / 100ps

module scan_point_curvature_top_tb;
	import spc_pkg::*;

	localparam int MIN_POINTS = 20;
	localparam int HALF_WIN   = 5;
	localparam int COORD_W    = 19;
	localparam int HIST_DEPTH = (MIN_POINTS > 2 * HALF_WIN + 1) ? MIN_POINTS : 2 * HALF_WIN + 1;
	localparam int REPORT_LIMIT = 10;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	typedef struct {
		logic signed [OUT_COORD_W-1:0] x;
		logic signed [OUT_COORD_W-1:0] y;
		logic signed [OUT_COORD_W-1:0] z;
		logic [CURV_W-1:0]             curv;
		logic                          curv_ok;
		logic                          last;
	} scan_report_t;

	logic clk = 1'b0;
	logic arst_n;

	spc_point_if #(.COORD_WIDTH(COORD_W)) point_ch ();
	spc_result_if result_ch ();

	scan_point_curvature_top #(
		.MIN_SCAN_POINTS(MIN_POINTS),
		.HALF_WINDOW(HALF_WIN),
		.COORD_WIDTH(COORD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(point_ch),
		.results(result_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: the window history of the current scan.
	coord_t       history [HIST_DEPTH][AXES];
	int unsigned  scan_count;
	int unsigned  ring_pos;
	scan_report_t expected_reports [$];

	int unsigned failures;
	int unsigned reports_seen;
	bit          calm;

	function automatic void report_failure(string msg);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("mismatch: %s", msg);
	endfunction

	function automatic int unsigned slot_of(int unsigned age);
		return (ring_pos + 2 * HIST_DEPTH - 1 - age) % HIST_DEPTH;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned b;
		rem  = v;
		root = 0;
		b    = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem  -= root + b;
				root  = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic logic [CURV_W-1:0] window_curvature(int unsigned age);
		longint          d;
		longint unsigned mag;
		longint unsigned sq;
		longint unsigned total;
		longint unsigned root;
		total = 0;
		for (int a = 0; a < AXES; a++) begin
			d = -longint'(2 * HALF_WIN) * longint'(history[slot_of(age)][a]);
			for (int k = 1; k <= HALF_WIN; k++) begin
				d += longint'(history[slot_of(age - k)][a]);
				d += longint'(history[slot_of(age + k)][a]);
			end
			mag = (d < 0) ? longint'(0) - d : d;
			sq = (mag > 64'hFFFF_FFFF) ? '1 : mag * mag;
			total = (total > ~sq) ? '1 : total + sq;
		end
		root = floor_sqrt(total);
		return (root > longint'(CURV_MAX)) ? CURV_MAX : root[CURV_W-1:0];
	endfunction

	function automatic void queue_report(int unsigned age, bit curv_ok, bit last);
		scan_report_t r;
		int unsigned  s;
		s = slot_of(age);
		r.x       = history[s][0];
		r.y       = history[s][1];
		r.z       = history[s][2];
		r.curv    = curv_ok ? window_curvature(age) : '0;
		r.curv_ok = curv_ok;
		r.last    = last;
		expected_reports.push_back(r);
	endfunction

	// Works out every report caused by one accepted point.
	function automatic void predict_point(coord_t x, coord_t y, coord_t z, bit eos);
		int unsigned prev;
		int unsigned cnt;
		prev = scan_count;
		history[ring_pos][0] = x;
		history[ring_pos][1] = y;
		history[ring_pos][2] = z;
		ring_pos = (ring_pos + 1) % HIST_DEPTH;
		cnt = (prev < HIST_DEPTH) ? prev + 1 : HIST_DEPTH;

		if (prev < MIN_POINTS && cnt < MIN_POINTS) begin
			if (eos)
				for (int unsigned j = 0; j < cnt; j++)
					queue_report(cnt - 1 - j, 1'b0, j == cnt - 1);
		end else if (prev < MIN_POINTS) begin
			// The scan just became long enough: flush all points whose right side is known.
			for (int unsigned j = 0; j + HALF_WIN < cnt; j++)
				queue_report(cnt - 1 - j, j >= HALF_WIN, 1'b0);
			if (eos)
				for (int a = HALF_WIN - 1; a >= 0; a--)
					queue_report(a, 1'b0, a == 0);
		end else begin
			queue_report(HALF_WIN, (prev >= HIST_DEPTH) || (prev >= 2 * HALF_WIN), 1'b0);
			if (eos)
				for (int a = HALF_WIN - 1; a >= 0; a--)
					queue_report(a, 1'b0, a == 0);
		end

		if (eos) begin
			scan_count = 0;
			ring_pos   = 0;
		end else begin
			scan_count = cnt;
		end
	endfunction

	// Drives one point and waits for its transaction; valid stays high for a following point.
	task automatic send_point(coord_t x, coord_t y, coord_t z, bit eos);
		int unsigned gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 20) begin
			gap = $urandom_range(1, 4);
			point_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		point_ch.valid       <= 1'b1;
		point_ch.x_coord     <= x;
		point_ch.y_coord     <= y;
		point_ch.z_coord     <= z;
		point_ch.end_of_scan <= eos;
		do
			@(posedge clk);
		while (point_ch.ready !== 1'b1);
		predict_point(x, y, z, eos);
	endtask

	function automatic coord_t pick_coord(coord_t base);
		int unsigned style;
		style = $urandom_range(0, 9);
		if (style < 4)
			return coord_t'($urandom);
		if (style < 8)
			return base + coord_t'($urandom_range(0, 400)) - coord_t'(200);
		case ($urandom_range(0, 3))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic send_random_scan(int unsigned len);
		coord_t bx;
		coord_t by;
		coord_t bz;
		bx = coord_t'($urandom);
		by = coord_t'($urandom);
		bz = coord_t'($urandom);
		for (int unsigned i = 0; i < len; i++) begin
			bx = pick_coord(bx);
			by = pick_coord(by);
			bz = pick_coord(bz);
			send_point(bx, by, bz, i == len - 1);
		end
	endtask

	task automatic test_single_point();
		send_point(COORD_MAX, COORD_MIN, '0, 1'b1);
	endtask

	task automatic test_short_extremes();
		send_point(COORD_MIN, COORD_MAX, '1, 1'b0);
		send_point('0, coord_t'(1), COORD_MIN, 1'b0);
		send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
	endtask

	// A scan of exactly the minimum length ending on its last point, with
	// alternating extremes so that the curvature is large.
	task automatic test_minimum_scan();
		for (int i = 0; i < MIN_POINTS; i++)
			send_point((i % 2) ? COORD_MAX : COORD_MIN,
				(i % 2) ? COORD_MIN : COORD_MAX,
				(i % 3 == 0) ? COORD_MAX : COORD_MIN,
				i == MIN_POINTS - 1);
	endtask

	task automatic test_random_scans(int unsigned budget);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(0, 19))
				0, 1, 2:  len = $urandom_range(1, MIN_POINTS - 1);
				3, 4, 5:  len = $urandom_range(MIN_POINTS, MIN_POINTS + 1);
				6:        len = $urandom_range(40, 60);
				default:  len = $urandom_range(MIN_POINTS + 2, 40);
			endcase
			send_random_scan(len);
			sent += len;
		end
	endtask

	task automatic test_unthrottled_stream();
		calm = 1'b1;
		send_random_scan(70);
		send_random_scan(MIN_POINTS - 1);
		send_random_scan(MIN_POINTS);
		calm = 1'b0;
	endtask

	// Result sink stall pattern.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
		end
	end

	always @(posedge clk) begin : check_reports
		scan_report_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			reports_seen++;
			if (expected_reports.size() == 0) begin
				report_failure($sformatf("report %0d arrived with none expected (x=%0d)",
					reports_seen, result_ch.out_x));
			end else begin
				want = expected_reports.pop_front();
				if (result_ch.out_x !== want.x || result_ch.out_y !== want.y ||
						result_ch.out_z !== want.z || result_ch.curvature !== want.curv ||
						result_ch.curvature_valid !== want.curv_ok ||
						result_ch.last_of_scan !== want.last)
					report_failure($sformatf(
						"report %0d want (%0d,%0d,%0d) %0d/%0b/%0b got (%0d,%0d,%0d) %0d/%0b/%0b",
						reports_seen, want.x, want.y, want.z, want.curv, want.curv_ok,
						want.last, result_ch.out_x, result_ch.out_y, result_ch.out_z,
						result_ch.curvature, result_ch.curvature_valid,
						result_ch.last_of_scan));
			end
		end
	end

	initial begin
		failures     = 0;
		reports_seen = 0;
		calm         = 1'b0;
		scan_count   = 0;
		ring_pos     = 0;
		arst_n               = 1'b0;
		point_ch.valid       = 1'b0;
		point_ch.x_coord     = '0;
		point_ch.y_coord     = '0;
		point_ch.z_coord     = '0;
		point_ch.end_of_scan = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_point();
		test_short_extremes();
		test_minimum_scan();
		test_random_scans(190);
		test_unthrottled_stream();

		@(negedge clk);
		point_ch.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		// Room for any stray report after the last expected one.
		repeat (2 * HALF_WIN + 40) @(posedge clk);
		if (expected_reports.size() != 0)
			report_failure($sformatf("%0d reports never arrived", expected_reports.size()));

		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Far beyond the slowest correct run, even if every point released twenty curvatures.
	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
